### hw/rtl/wfpt_pkg.sv
// Package: constants, payload structs and command types of the worker frontier progress table
`timescale 1ns / 1ps
package wfpt_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int MAX_STRATA  = 64;
    localparam int WORKER_W    = 4;
    localparam int STRATUM_W   = 6;
    localparam int WCOUNT_W    = 5;
    localparam int SCOUNT_W    = 7;
    localparam int ADDR_W      = STRATUM_W + WORKER_W;
    localparam int SLOT_TOTAL  = MAX_WORKERS * MAX_STRATA;
    localparam int DATA_W      = 32;
    localparam int SLOT_W      = 2 * DATA_W;
    localparam int PADDR_W     = 3;

    localparam logic [DATA_W-1:0] SENTINEL = '1;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    localparam logic REG_WORKER_COUNT  = 1'b0;
    localparam logic REG_STRATUM_COUNT = 1'b1;

    localparam logic [WCOUNT_W-1:0] WORKER_COUNT_RST  = 5'd16;
    localparam logic [SCOUNT_W-1:0] STRATUM_COUNT_RST = 7'd64;

    localparam logic [1:0] KIND_RECORD     = 2'd0;
    localparam logic [1:0] KIND_QUERY      = 2'd1;
    localparam logic [1:0] KIND_RESET      = 2'd2;
    localparam logic [1:0] KIND_QUERY_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]           operation;
        logic [WORKER_W-1:0]  worker;
        logic [STRATUM_W-1:0] stratum;
        logic [DATA_W-1:0]    epoch;
        logic [DATA_W-1:0]    iteration_value;
    } req_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] min_iteration;
        logic              all_converged;
    } rsp_word_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [WORKER_W-1:0]  worker;
        logic [STRATUM_W-1:0] stratum;
        logic [DATA_W-1:0]    epoch;
        logic [DATA_W-1:0]    iteration;
        logic [WCOUNT_W-1:0]  count;
    } cmd_t;

endpackage

### hw/rtl/wfpt_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module wfpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/wfpt_front.sv
// Front end: accept request words, classify them and queue commands for the back end
`timescale 1ns / 1ps
module wfpt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  wfpt_pkg::req_word_t           req,
    input  logic [wfpt_pkg::WCOUNT_W-1:0] worker_count,
    input  logic [wfpt_pkg::SCOUNT_W-1:0] stratum_count,
    input  logic                          clearing,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output wfpt_pkg::cmd_t                cmd
);
    import wfpt_pkg::*;

    logic [WCOUNT_W-1:0] nw;
    logic [SCOUNT_W-1:0] ns;
    logic                s_ok;
    logic                w_ok;
    logic                keep;
    cmd_t                cls;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    always_comb
    begin
        nw = (worker_count > WCOUNT_W'(MAX_WORKERS)) ? WCOUNT_W'(MAX_WORKERS) : worker_count;
        ns = (stratum_count > SCOUNT_W'(MAX_STRATA)) ? SCOUNT_W'(MAX_STRATA) : stratum_count;
        s_ok = {1'b0, req.stratum} < ns;
        w_ok = {1'b0, req.worker} < nw;
        cls.worker    = req.worker;
        cls.stratum   = req.stratum;
        cls.epoch     = req.epoch;
        cls.iteration = req.iteration_value;
        cls.count     = nw;
        cls.kind      = KIND_RECORD;
        keep          = 1'b0;
        case (req.operation)
            OP_RECORD:
            begin
                cls.kind = KIND_RECORD;
                keep     = s_ok && w_ok;
            end
            OP_RESET:
            begin
                cls.kind = KIND_RESET;
                keep     = s_ok && (nw != '0);
            end
            OP_QUERY:
            begin
                cls.kind = (s_ok && (nw != '0)) ? KIND_QUERY : KIND_QUERY_NONE;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign req_ready = (cnt_reg != 2'd2) && !clearing;
    assign push      = req_valid && req_ready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### hw/rtl/wfpt_back.sv
// Back end: clearing pass, slot walks over the table RAM and the result register
`timescale 1ns / 1ps
module wfpt_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  wfpt_pkg::cmd_t              cmd,
    output logic                        clearing,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output wfpt_pkg::rsp_word_t         rsp
);
    import wfpt_pkg::*;

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_WALK_WR = 3'd2;
    localparam logic [2:0] ST_WALK_RD = 3'd3;
    localparam logic [2:0] ST_DRAIN   = 3'd4;
    localparam logic [2:0] ST_PUBLISH = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [WCOUNT_W-1:0] wk_reg, wk_next;
    cmd_t                cur_reg, cur_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [DATA_W-1:0]   least_reg, least_next;
    logic                conv_reg, conv_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_word_t           rsp_reg, rsp_next;

    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [SLOT_W-1:0]   wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
    logic [SLOT_W-1:0]   rdata;
    logic [DATA_W-1:0]   rd_epoch;
    logic [DATA_W-1:0]   rd_iter;
    logic                last_wk;
    logic                take;

    wfpt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_TOTAL)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign clearing  = (state_reg == ST_CLEAR);
    assign take      = cmd_valid && cmd_ready;
    assign last_wk   = (wk_reg == cur_reg.count - WCOUNT_W'(1));
    assign rd_epoch  = rdata[SLOT_W-1:DATA_W];
    assign rd_iter   = rdata[DATA_W-1:0];
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wk_next        = wk_reg;
        cur_next       = cur_reg;
        rd_pend_next   = 1'b0;
        least_next     = least_reg;
        conv_next      = conv_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        we             = 1'b0;
        waddr          = {cmd.stratum, cmd.worker};
        wdata          = {cmd.epoch, cmd.iteration};
        re             = 1'b0;
        raddr          = {cur_reg.stratum, wk_reg[WORKER_W-1:0]};

        if (rd_pend_reg)
        begin
            if (rd_epoch != cur_reg.epoch || rd_iter == SENTINEL)
            begin
                conv_next = 1'b0;
            end
            if (rd_epoch == cur_reg.epoch && rd_iter < least_reg)
            begin
                least_next = rd_iter;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = {{DATA_W{1'b0}}, SENTINEL};
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(SLOT_TOTAL - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    cur_next   = cmd;
                    wk_next    = '0;
                    least_next = SENTINEL;
                    case (cmd.kind)
                        KIND_RECORD:
                        begin
                            we = 1'b1;
                        end
                        KIND_RESET:
                        begin
                            state_next = ST_WALK_WR;
                        end
                        KIND_QUERY:
                        begin
                            conv_next  = 1'b1;
                            state_next = ST_WALK_RD;
                        end
                        default:
                        begin
                            conv_next  = 1'b0;
                            state_next = ST_PUBLISH;
                        end
                    endcase
                end
            end
            ST_WALK_WR:
            begin
                we      = 1'b1;
                waddr   = {cur_reg.stratum, wk_reg[WORKER_W-1:0]};
                wdata   = {cur_reg.epoch, SENTINEL};
                wk_next = wk_reg + WCOUNT_W'(1);
                if (last_wk)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK_RD:
            begin
                re           = 1'b1;
                rd_pend_next = 1'b1;
                wk_next      = wk_reg + WCOUNT_W'(1);
                if (last_wk)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.min_iteration = least_reg;
                    rsp_next.all_converged = conv_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wk_reg        <= '0;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wk_reg        <= wk_next;
            rd_pend_reg   <= rd_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        least_reg <= least_next;
        conv_reg  <= conv_next;
        rsp_reg   <= rsp_next;
    end

    a_no_write_on_read_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_RD) |-> !we)
        else $error("table write during query walk");

    a_read_data_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == ST_WALK_RD || state_reg == ST_DRAIN))
        else $error("read data arrives outside a query walk");

    a_walk_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_RD || state_reg == ST_WALK_WR) |-> (wk_reg < cur_reg.count))
        else $error("slot walk past worker count");

    a_publish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUBLISH && (!rsp_valid_reg || rsp_ready)) |=> rsp_valid_reg)
        else $error("query result not loaded");

endmodule

### hw/rtl/worker_frontier_progress_table.sv
// Top level: configuration registers and the front and back ends of the progress table
// Record: written to the table RAM by the back end as it takes the word from the two-entry command queue.
// Reset stratum: dispatched from the idle state, then one table write per worker in use.
// Query: one RAM read per worker in use, then the drain and publish states load the result register.
// After reset all 1024 slots are cleared, one slot a cycle, with req_ready low.
// Configuration registers reset to 16 workers and 64 strata.
`timescale 1ns / 1ps
module worker_frontier_progress_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  wfpt_pkg::req_word_t          req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output wfpt_pkg::rsp_word_t          rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wfpt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import wfpt_pkg::*;

    logic [WCOUNT_W-1:0] worker_count_reg, worker_count_next;
    logic [SCOUNT_W-1:0] stratum_count_reg, stratum_count_next;
    logic                cfg_wr;
    logic                clearing;
    logic                cmd_valid;
    logic                cmd_ready;
    cmd_t                cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        worker_count_next  = worker_count_reg;
        stratum_count_next = stratum_count_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_WORKER_COUNT:  worker_count_next  = pwdata[WCOUNT_W-1:0];
                REG_STRATUM_COUNT: stratum_count_next = pwdata[SCOUNT_W-1:0];
                default:           worker_count_next  = worker_count_reg;
            endcase
        end
        case (paddr[2])
            REG_WORKER_COUNT:  prdata = {{(32 - WCOUNT_W){1'b0}}, worker_count_reg};
            REG_STRATUM_COUNT: prdata = {{(32 - SCOUNT_W){1'b0}}, stratum_count_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            worker_count_reg  <= WORKER_COUNT_RST;
            stratum_count_reg <= STRATUM_COUNT_RST;
        end
        else
        begin
            worker_count_reg  <= worker_count_next;
            stratum_count_reg <= stratum_count_next;
        end
    end

    wfpt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .worker_count  (worker_count_reg),
        .stratum_count (stratum_count_reg),
        .clearing      (clearing),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    wfpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

### test/frontier_checker.sv
// Checker: mirrors the progress table, predicts every query result and compares the responses
`timescale 1ns / 1ps
module frontier_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic                         req_ready,
    input  wfpt_pkg::req_word_t          req,
    input  logic                         rsp_valid,
    input  logic                         rsp_ready,
    input  wfpt_pkg::rsp_word_t          rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wfpt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,
    output int                           fail_count,
    output int                           frontier_pending,
    output int                           frontier_count,
    output int                           converged_count
);
    import wfpt_pkg::*;

    logic [DATA_W-1:0]   slot_ep [SLOT_TOTAL];
    logic [DATA_W-1:0]   slot_it [SLOT_TOTAL];
    logic [WCOUNT_W-1:0] wcount;
    logic [SCOUNT_W-1:0] scount;
    rsp_word_t           frontier_q [$];

    function automatic void count_mismatch(input string what, input logic [31:0] want,
                                           input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $time);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int          nw;
        int          ns;
        int          base;
        rsp_word_t   want;
        logic [31:0] reg_want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_TOTAL; i++)
            begin
                slot_ep[i] = '0;
                slot_it[i] = SENTINEL;
            end
            wcount = WORKER_COUNT_RST;
            scount = STRATUM_COUNT_RST;
            frontier_q.delete();
            fail_count = 0;
            frontier_pending = 0;
            frontier_count = 0;
            converged_count = 0;
        end
        else
        begin
            nw = (wcount > MAX_WORKERS) ? MAX_WORKERS : int'(wcount);
            ns = (scount > MAX_STRATA) ? MAX_STRATA : int'(scount);

            if (rsp_valid && rsp_ready)
            begin
                if (frontier_q.size() == 0)
                begin
                    count_mismatch("response with none pending", '0, rsp.min_iteration);
                end
                else
                begin
                    want = frontier_q.pop_front();
                    if (rsp.min_iteration !== want.min_iteration)
                        count_mismatch("min_iteration", want.min_iteration, rsp.min_iteration);
                    if (rsp.all_converged !== want.all_converged)
                        count_mismatch("all_converged", 32'(want.all_converged),
                                       32'(rsp.all_converged));
                end
            end

            if (req_valid && req_ready)
            begin
                base = int'(req.stratum) * MAX_WORKERS;
                case (req.operation)
                    OP_RECORD:
                    begin
                        if (req.worker < nw && req.stratum < ns)
                        begin
                            slot_ep[base + int'(req.worker)] = req.epoch;
                            slot_it[base + int'(req.worker)] = req.iteration_value;
                        end
                    end
                    OP_RESET:
                    begin
                        if (req.stratum < ns)
                        begin
                            for (int i = 0; i < nw; i++)
                            begin
                                slot_ep[base + i] = req.epoch;
                                slot_it[base + i] = SENTINEL;
                            end
                        end
                    end
                    OP_QUERY:
                    begin
                        want.min_iteration = SENTINEL;
                        want.all_converged = 1'b0;
                        if (req.stratum < ns && nw > 0)
                        begin
                            want.all_converged = 1'b1;
                            for (int i = 0; i < nw; i++)
                            begin
                                if (slot_ep[base + i] != req.epoch || slot_it[base + i] == SENTINEL)
                                    want.all_converged = 1'b0;
                                if (slot_ep[base + i] == req.epoch
                                        && slot_it[base + i] < want.min_iteration)
                                    want.min_iteration = slot_it[base + i];
                            end
                        end
                        frontier_q.push_back(want);
                        frontier_count++;
                        if (want.all_converged)
                            converged_count++;
                    end
                    default: ;
                endcase
            end

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_WORKER_COUNT)
                        wcount = pwdata[WCOUNT_W-1:0];
                    else
                        scount = pwdata[SCOUNT_W-1:0];
                end
                else
                begin
                    reg_want = (paddr[2] == REG_WORKER_COUNT) ? 32'(wcount) : 32'(scount);
                    if (prdata !== reg_want)
                        count_mismatch("register read", reg_want, prdata);
                end
            end

            frontier_pending = frontier_q.size();
        end
    end

endmodule

### test/tb_top.sv
// Testbench top: clock, reset, word and register stimulus for the progress table, and the verdict
`timescale 1ns / 1ps
module tb_top;
    import wfpt_pkg::*;

    localparam logic [1:0]         OP_UNUSED    = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_WORKERS = {REG_WORKER_COUNT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_STRATA  = {REG_STRATUM_COUNT, 2'b00};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    req_word_t          req;
    logic               rsp_valid;
    logic               rsp_ready;
    rsp_word_t          rsp;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int frontier_pending;
    int frontier_count;
    int converged_count;

    logic quiet;
    int   hold_asks;
    int   words_sent;
    int   settings_used;
    int   wc_now;
    int   sc_now;

    always #4 clk = ~clk;

    worker_frontier_progress_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    frontier_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req              (req),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .rsp              (rsp),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .fail_count       (fail_count),
        .frontier_pending (frontier_pending),
        .frontier_count   (frontier_count),
        .converged_count  (converged_count)
    );

    function automatic req_word_t word_of(input logic [1:0] op, input logic [WORKER_W-1:0] wk,
                                          input logic [STRATUM_W-1:0] st,
                                          input logic [DATA_W-1:0] ep,
                                          input logic [DATA_W-1:0] it);
        req_word_t w;
        w.operation       = op;
        w.worker          = wk;
        w.stratum         = st;
        w.epoch           = ep;
        w.iteration_value = it;
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] pick_epoch();
        case ($urandom_range(0, 9))
            0:             return '0;
            1:             return '1;
            2, 3, 4, 5:    return DATA_W'($urandom_range(0, 3));
            default:       return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_iter();
        case ($urandom_range(0, 9))
            0:             return '0;
            1:             return SENTINEL;
            2:             return SENTINEL - 1;
            3, 4, 5:       return DATA_W'($urandom_range(0, 15));
            default:       return $urandom;
        endcase
    endfunction

    // call at a falling edge; return at a falling edge with valid still high unless idling
    task automatic push_word(input req_word_t w);
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 99) < 17)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop valid, drain every pending result, then let queued records and resets finish
    task automatic settle();
        req_valid <= 1'b0;
        while (frontier_pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic apply(input int wc, input int sc);
        settle();
        reg_access(1'b1, ADDR_WORKERS, 32'(wc));
        reg_access(1'b1, ADDR_STRATA, 32'(sc));
        reg_access(1'b0, ADDR_WORKERS, '0);
        reg_access(1'b0, ADDR_STRATA, '0);
        wc_now = wc;
        sc_now = sc;
        settings_used++;
    endtask

    // optionally reset a stratum, report from its workers, then ask for its frontier
    task automatic converge_run(output int cnt);
        int                    nw;
        int                    ns;
        logic                  full;
        logic [STRATUM_W-1:0]  st;
        logic [DATA_W-1:0]     ep;
        logic [DATA_W-1:0]     it;
        nw   = (wc_now > MAX_WORKERS) ? MAX_WORKERS : wc_now;
        ns   = (sc_now > MAX_STRATA) ? MAX_STRATA : sc_now;
        full = ($urandom_range(0, 9) < 6);
        st   = (ns > 0 && $urandom_range(0, 9) != 0) ? STRATUM_W'($urandom_range(0, ns - 1))
                                                     : STRATUM_W'($urandom);
        ep   = pick_epoch();
        cnt  = 0;
        if ($urandom_range(0, 3) != 0)
        begin
            push_word(word_of(OP_RESET, WORKER_W'($urandom), st, ep, $urandom));
            cnt++;
        end
        for (int i = 0; i < nw; i++)
        begin
            if (full || $urandom_range(0, 5) != 0)
            begin
                it = pick_iter();
                if (full && it == SENTINEL)
                    it = SENTINEL - 1;
                push_word(word_of(OP_RECORD, WORKER_W'(i), st,
                                  (!full && $urandom_range(0, 9) == 0) ? pick_epoch() : ep, it));
                cnt++;
            end
        end
        push_word(word_of(OP_QUERY, WORKER_W'($urandom), st, ep, $urandom));
        cnt++;
        if ($urandom_range(0, 3) == 0)
        begin
            push_word(word_of(OP_QUERY, WORKER_W'($urandom), st, pick_epoch(), $urandom));
            cnt++;
        end
    endtask

    task automatic random_phase(input int goal);
        int n;
        int cnt;
        req_word_t w;
        n = 0;
        while (n < goal)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                converge_run(cnt);
                n += cnt;
            end
            else
            begin
                w = word_of(2'($urandom_range(0, 3)), WORKER_W'($urandom), STRATUM_W'($urandom),
                            pick_epoch(), pick_iter());
                push_word(w);
                if (w.operation != OP_UNUSED)
                    n++;
            end
        end
    endtask

    initial
    begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ready <= quiet || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    initial
    begin : stimulus
        req_valid     = 1'b0;
        req           = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        quiet         = 1'b0;
        hold_asks     = 0;
        words_sent    = 0;
        settings_used = 1;
        wc_now        = int'(WORKER_COUNT_RST);
        sc_now        = int'(STRATUM_COUNT_RST);
        rst_n         = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        reg_access(1'b0, ADDR_WORKERS, '0);
        reg_access(1'b0, ADDR_STRATA, '0);

        push_word(word_of(OP_QUERY, 4'd0, 6'd0, '0, '0));
        push_word(word_of(OP_RECORD, 4'd0, 6'd0, '0, '0));
        push_word(word_of(OP_QUERY, 4'd0, 6'd0, '0, '1));
        push_word(word_of(OP_RECORD, 4'd15, 6'd63, '1, SENTINEL - 1));
        push_word(word_of(OP_QUERY, 4'd15, 6'd63, '1, '0));
        push_word(word_of(OP_RESET, 4'd0, 6'd63, 32'd5, '0));
        push_word(word_of(OP_QUERY, 4'd0, 6'd63, 32'd5, '0));
        push_word(word_of(OP_QUERY, 4'd0, 6'd63, '1, '0));
        push_word(word_of(OP_UNUSED, 4'd0, 6'd0, '0, '0));
        push_word(word_of(OP_RECORD, 4'd3, 6'd0, '0, SENTINEL));
        push_word(word_of(OP_QUERY, 4'd0, 6'd0, '0, '0));

        apply(1, 3);
        push_word(word_of(OP_RECORD, 4'd0, 6'd2, 32'd9, 32'd4));
        push_word(word_of(OP_RECORD, 4'd1, 6'd2, 32'd9, 32'd1));
        push_word(word_of(OP_QUERY, 4'd0, 6'd2, 32'd9, '0));
        push_word(word_of(OP_QUERY, 4'd0, 6'd3, 32'd9, '0));
        push_word(word_of(OP_RECORD, 4'd0, 6'd3, 32'd9, 32'd2));
        push_word(word_of(OP_RESET, 4'd0, 6'd3, 32'd1, '0));

        apply(0, 3);
        push_word(word_of(OP_RECORD, 4'd0, 6'd0, '0, 32'd5));
        push_word(word_of(OP_RESET, 4'd0, 6'd2, '0, '0));
        push_word(word_of(OP_QUERY, 4'd0, 6'd2, 32'd9, '0));

        apply(31, 0);
        push_word(word_of(OP_QUERY, 4'd0, 6'd0, '0, '0));
        push_word(word_of(OP_RECORD, 4'd0, 6'd0, '0, 32'd1));

        apply(31, 127);
        push_word(word_of(OP_RECORD, 4'd15, 6'd63, 32'd5, 32'd7));
        push_word(word_of(OP_QUERY, 4'd0, 6'd63, 32'd5, '0));

        apply(16, 64);
        hold_asks <= hold_asks + 1;
        repeat (12)
            push_word(word_of(OP_QUERY, WORKER_W'($urandom), STRATUM_W'($urandom),
                              pick_epoch(), $urandom));
        random_phase(110);
        apply(1, 1);
        random_phase(110);
        apply(0, 5);
        random_phase(60);
        apply(3, 0);
        random_phase(60);
        apply(31, 127);
        quiet <= 1'b1;
        random_phase(120);
        quiet <= 1'b0;
        apply(8, 12);
        random_phase(120);
        apply($urandom_range(1, 16), $urandom_range(1, 64));
        random_phase(120);
        apply(16, 2);
        random_phase(120);
        apply(2, 64);
        random_phase(110);
        settle();

        $display("covered %0d words over %0d register settings, %0d frontier queries answered",
                 words_sent, settings_used, frontier_count);
        $display("%0d of those queries found every worker in use converged", converged_count);
        if (fail_count == 0)
            $display("PASS worker_frontier_progress_table");
        else
            $display("FAIL worker_frontier_progress_table");
        $finish;
    end

    initial
    begin : watchdog
        #4000000;
        $display("FAIL worker_frontier_progress_table");
        $finish;
    end

endmodule
